@@ hdl/fnvh_pkg.sv @@
package fnvh_pkg;

	localparam int HASH_W      = 32;
	localparam int BYTE_W      = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
	localparam logic [HASH_W-1:0] MIX_MUL_A = 32'h21f0aaad;
	localparam logic [HASH_W-1:0] MIX_MUL_B = 32'h735a2d97;
	localparam int                MIX_SH_A  = 16;
	localparam int                MIX_SH_B  = 15;

	typedef logic [HASH_W-1:0] hash_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fnvh_qstat_t;

	function automatic hash_t mul_lo(input hash_t a, input hash_t b);
		logic [2*HASH_W-1:0] p;
		begin
			p = {{HASH_W{1'b0}}, a} * {{HASH_W{1'b0}}, b};
			return p[HASH_W-1:0];
		end
	endfunction

	function automatic hash_t xor_shift(input hash_t h, input int sh);
		begin
			return h ^ (h >> sh);
		end
	endfunction

endpackage

@@ hdl/fnvh_queue.sv @@
module fnvh_queue import fnvh_pkg::*; #(
	parameter int WIDTH = HASH_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output fnvh_qstat_t      stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hdl/fnvh_front.sv @@
module fnvh_front import fnvh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              has_byte,
	input  logic              first_item,
	input  logic              last_item,
	input  fnvh_qstat_t       qstat,
	output logic              full,
	output logic              fin_push,
	output hash_t             fin_data
);

	hash_t run_q;
	hash_t start;
	hash_t next_h;
	logic  accept;

	assign full   = qstat.full;
	assign accept = push && !full;
	assign start  = first_item ? FNV_BASIS : run_q;
	assign next_h = has_byte ? mul_lo(start ^ {{(HASH_W-BYTE_W){1'b0}}, data_byte}, FNV_PRIME)
	                         : start;

	assign fin_push = accept && last_item;
	assign fin_data = next_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= FNV_BASIS;
		end else if (accept) begin
			run_q <= last_item ? FNV_BASIS : next_h;
		end
	end

endmodule

@@ hdl/fnvh_back.sv @@
module fnvh_back import fnvh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hash_t       q_data,
	input  fnvh_qstat_t qstat,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output hash_t       hash_value
);

	hash_t mix_s1;
	hash_t mix_s2;
	logic  vld_s1;
	logic  vld_s2;
	logic  adv_s1;
	logic  adv_s2;

	assign adv_s2     = !vld_s2 || pop;
	assign adv_s1     = !vld_s1 || adv_s2;
	assign q_pop      = adv_s1 && !qstat.empty;
	assign empty      = !vld_s2;
	assign hash_value = xor_shift(mix_s2, MIX_SH_B);

	// first mix round, then second
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mix_s1 <= mul_lo(xor_shift(q_data, MIX_SH_A), MIX_MUL_A);
		end
		if (adv_s2) begin
			mix_s2 <= mul_lo(xor_shift(mix_s1, MIX_SH_B), MIX_MUL_B);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= !qstat.empty;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

endmodule

@@ hdl/fnv1a_string_hash_finalized.sv @@
// fnv1a string hash with a low-bias 32-bit mix finalizer
// input channel: one byte per item (data_byte, has_byte, first_item,
// last_item), taken at a clock edge with push high and full low
// first_item restarts the running state from the offset basis, an item
// without a byte leaves the state as it is, last_item finalizes the string
// result channel: hash_value is valid while empty is low and is taken at an
// edge with pop high; one result per item marked last
// throughput: one item per cycle while full is low; the fnv step is one
// constant multiply on the running state register, done in the cycle the
// item is taken; a finished hash goes through the queue and then the two
// registered multiply rounds of the finalizer before it shows on hash_value
// finished strings wait in a small queue (QUEUE_DEPTH_P entries) between the
// byte front end and the finalizer; while the receiver holds off pop the
// finalizer stalls, the queue fills, and full rises once it has no room
// reset: running state returns to the offset basis, queue and finalizer
// empty, empty high
module fnv1a_string_hash_finalized import fnvh_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              has_byte,
	input  logic              first_item,
	input  logic              last_item,
	output logic              empty,
	input  logic              pop,
	output logic [HASH_W-1:0] hash_value
);

	fnvh_qstat_t qstat;
	logic        fin_push;
	hash_t       fin_data;
	logic        q_pop;
	hash_t       q_data;

	fnvh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.first_item (first_item),
		.last_item  (last_item),
		.qstat      (qstat),
		.full       (full),
		.fin_push   (fin_push),
		.fin_data   (fin_data)
	);

	fnvh_queue #(
		.WIDTH (HASH_W),
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fin_push),
		.wr_data (fin_data),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.stat    (qstat)
	);

	fnvh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_data),
		.qstat      (qstat),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.hash_value (hash_value)
	);

endmodule
